### rtl/core/drr_pkg.sv
package drr_pkg;

    localparam int DEF_FLOWS      = 64;
    localparam int DEF_FLOW_DEPTH = 32;
    localparam int MAX_RESULTS    = 25;

    localparam int KEY_W      = 31;
    localparam int SIZE_W     = 11;
    localparam int KIND_W     = 3;
    localparam int OFLOW_W    = 6;
    localparam int QUANTUM_W  = 16;
    localparam int LIMIT_W    = 20;
    localparam int FIU_W      = 7;
    localparam int TOTAL_W    = 21;
    localparam int DEFICIT_W  = 17;
    localparam int NRES_W     = 5;
    localparam int MAX_PKT    = 1518;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 24;

    localparam logic [QUANTUM_W-1:0] RESET_QUANTUM = QUANTUM_W'(1500);
    localparam logic [LIMIT_W-1:0]   RESET_LIMIT   = LIMIT_W'(10 * 1024);
    localparam logic [FIU_W-1:0]     RESET_FIU     = FIU_W'(64);

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOWS_IN_USE = 2'd2;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQUEUED,
        KIND_UNCLASSIFIED,
        KIND_OVERLIMIT,
        KIND_DEQUEUED,
        KIND_EMPTY,
        KIND_FLOW_FULL
    } drr_kind_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_MOD,
        ST_ENQ_RD,
        ST_ENQ_UPD,
        ST_EMIT,
        ST_SCAN,
        ST_DROP_RD,
        ST_DROP_SZ,
        ST_DROP_UPD,
        ST_DQ_START,
        ST_DQ_RF,
        ST_DQ_CHK,
        ST_DQ_SZ
    } drr_state_t;

    typedef struct packed {
        drr_state_t op;
        logic       accept;
    } drr_cmd_t;

    typedef struct packed {
        logic init_done;
        logic is_deq;
        logic is_miss;
        logic mod_done;
        logic out_free;
        logic last_emit;
        logic scan_done;
        logic ring_empty;
        logic flow_empty;
        logic covers;
    } drr_status_t;

endpackage

### rtl/core/drr_ctrl.sv
module drr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  drr_pkg::drr_status_t status,
    output drr_pkg::drr_cmd_t    cmd
);

    drr_pkg::drr_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= drr_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            drr_pkg::ST_INIT: begin
                if (status.init_done) state_next = drr_pkg::ST_IDLE;
            end
            drr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) state_next = drr_pkg::ST_DECODE;
            end
            drr_pkg::ST_DECODE: begin
                if (status.is_deq) begin
                    state_next = drr_pkg::ST_DQ_START;
                end else if (status.is_miss) begin
                    state_next = drr_pkg::ST_EMIT;
                end else begin
                    state_next = drr_pkg::ST_MOD;
                end
            end
            drr_pkg::ST_MOD: begin
                if (status.mod_done) state_next = drr_pkg::ST_ENQ_RD;
            end
            drr_pkg::ST_ENQ_RD:   state_next = drr_pkg::ST_ENQ_UPD;
            drr_pkg::ST_ENQ_UPD:  state_next = drr_pkg::ST_EMIT;
            drr_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    state_next = status.last_emit ? drr_pkg::ST_IDLE : drr_pkg::ST_SCAN;
                end
            end
            drr_pkg::ST_SCAN: begin
                if (status.scan_done) state_next = drr_pkg::ST_DROP_RD;
            end
            drr_pkg::ST_DROP_RD:  state_next = drr_pkg::ST_DROP_SZ;
            drr_pkg::ST_DROP_SZ:  state_next = drr_pkg::ST_DROP_UPD;
            drr_pkg::ST_DROP_UPD: state_next = drr_pkg::ST_EMIT;
            drr_pkg::ST_DQ_START: begin
                state_next = status.ring_empty ? drr_pkg::ST_EMIT : drr_pkg::ST_DQ_RF;
            end
            drr_pkg::ST_DQ_RF:    state_next = drr_pkg::ST_DQ_CHK;
            drr_pkg::ST_DQ_CHK: begin
                state_next = status.flow_empty ? drr_pkg::ST_DQ_START : drr_pkg::ST_DQ_SZ;
            end
            drr_pkg::ST_DQ_SZ: begin
                state_next = status.covers ? drr_pkg::ST_EMIT : drr_pkg::ST_DQ_START;
            end
            default: state_next = drr_pkg::ST_INIT;
        endcase
    end

    assign cmd.op     = state_reg;
    assign cmd.accept = s_tready & s_tvalid;

    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> state_reg == drr_pkg::ST_DECODE)
        else $error("accepted transaction did not move to decode");

    a_no_accept_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        !status.init_done |-> !s_tready)
        else $error("input ready before clearing pass finished");

    a_emit_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == drr_pkg::ST_EMIT && status.out_free && status.last_emit)
        |=> state_reg == drr_pkg::ST_IDLE)
        else $error("final result did not return to idle");

endmodule

### rtl/core/drr_dpath.sv
module drr_dpath #(
    parameter int FLOWS      = drr_pkg::DEF_FLOWS,
    parameter int FLOW_DEPTH = drr_pkg::DEF_FLOW_DEPTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  drr_pkg::drr_cmd_t                  cmd,
    output drr_pkg::drr_status_t               status,
    input  logic [drr_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [drr_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic                               cfg_valid,
    input  logic [drr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [drr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [drr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [drr_pkg::KIND_W-1:0]         m_tuser,
    output logic                               m_tlast
);

    localparam int FW    = $clog2(FLOWS);
    localparam int MW    = $clog2(FLOWS + 1);
    localparam int PW    = $clog2(FLOW_DEPTH);
    localparam int CW    = $clog2(FLOW_DEPTH + 1);
    localparam int BL_W  = $clog2(FLOW_DEPTH * drr_pkg::MAX_PKT + 1);
    localparam int SAW   = $clog2(FLOWS * FLOW_DEPTH);
    localparam int SCW   = $clog2(FLOWS + 1);
    localparam int DW    = drr_pkg::DEFICIT_W;
    localparam int SW    = drr_pkg::SIZE_W;
    localparam int TW    = drr_pkg::TOTAL_W;

    typedef struct packed {
        logic [DW-1:0]   deficit;
        logic            active;
        logic [BL_W-1:0] backlog;
        logic [PW-1:0]   head;
        logic [PW-1:0]   tail;
        logic [CW-1:0]   count;
    } flow_rec_t;

    flow_rec_t          flow_mem [FLOWS];
    logic [SW-1:0]      size_mem [FLOWS * FLOW_DEPTH];
    logic [FW-1:0]      ring_mem [FLOWS];

    // Configuration.
    logic [drr_pkg::QUANTUM_W-1:0] quantum_reg;
    logic [drr_pkg::LIMIT_W-1:0]   limit_reg;
    logic [drr_pkg::FIU_W-1:0]     fiu_reg;

    // Item being worked on.
    logic [drr_pkg::KEY_W-1:0] key_reg;
    logic [SW-1:0]             isize_reg;
    logic                      deq_reg;
    logic                      miss_reg;

    logic [SCW-1:0]  init_cnt_reg;
    logic [MW-1:0]   rem_reg;
    logic [4:0]      mod_cnt_reg;
    logic [TW-1:0]   total_reg, total_next;
    logic [FW-1:0]   ring_head_reg, ring_tail_reg;
    logic [SCW-1:0]  ring_cnt_reg;
    logic            credited_reg;
    logic [DW-1:0]   def_reg;
    logic [drr_pkg::NRES_W-1:0] n_reg;
    logic [SCW-1:0]  scan_cnt_reg;
    logic            scan_pend_reg;
    logic [FW-1:0]   scan_idx_reg;
    logic [BL_W-1:0] best_reg;
    logic [FW-1:0]   fat_reg;

    drr_pkg::drr_kind_t pend_kind_reg;
    logic [FW-1:0]      pend_flow_reg;
    logic [SW-1:0]      pend_size_reg;

    logic               out_valid_reg;
    drr_pkg::drr_kind_t out_kind_reg;
    logic [FW-1:0]      out_flow_reg;
    logic [SW-1:0]      out_size_reg;
    logic               out_last_reg;

    flow_rec_t     rec_q;
    logic [SW-1:0] size_q;
    logic [FW-1:0] ring_q;

    // Memory port controls.
    logic          frd_en, fwr_en;
    logic [FW-1:0] frd_addr, fwr_addr;
    flow_rec_t     fwr_data;
    logic          srd_en, swr_en;
    logic [SAW-1:0] srd_addr, swr_addr;
    logic          rrd_en;
    logic          ring_push, ring_pop;
    logic [FW-1:0] rwr_data;

    logic [MW-1:0]   mod_eff;
    logic [MW:0]     rem_shift;
    logic [MW-1:0]   rem_step;
    logic [FW-1:0]   enq_f;
    logic [DW-1:0]   q_eff;
    logic            init_done;
    logic            full;
    logic            out_free;
    logic            emit_load;
    logic            over_limit;
    logic            last_emit;
    logic            covers;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(FLOW_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [FW-1:0] ring_inc(input logic [FW-1:0] p);
        ring_inc = (p == FW'(FLOWS - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [SAW-1:0] size_addr(input logic [FW-1:0] f,
                                                  input logic [PW-1:0] p);
        size_addr = SAW'(f) * SAW'(FLOW_DEPTH) + SAW'(p);
    endfunction

    // Zero means one, and anything above the flow count means the flow count.
    always_comb begin
        if (fiu_reg == '0) begin
            mod_eff = MW'(1);
        end else if (32'(fiu_reg) > FLOWS) begin
            mod_eff = MW'(FLOWS);
        end else begin
            mod_eff = MW'(fiu_reg);
        end
    end

    // One key bit per cycle of restoring remainder.
    assign rem_shift = {rem_reg, key_reg[mod_cnt_reg]};
    assign rem_step  = (rem_shift >= {1'b0, mod_eff}) ? MW'(rem_shift - {1'b0, mod_eff})
                                                      : MW'(rem_shift);
    assign enq_f     = rem_reg[FW-1:0];

    assign q_eff      = (quantum_reg == '0) ? DW'(1) : DW'(quantum_reg);
    assign init_done  = (init_cnt_reg == SCW'(FLOWS));
    assign full       = (rec_q.count >= CW'(FLOW_DEPTH));
    assign out_free   = !out_valid_reg || m_tready;
    assign emit_load  = (cmd.op == drr_pkg::ST_EMIT) && out_free;
    assign over_limit = (total_reg > TW'(limit_reg));
    assign last_emit  = deq_reg || miss_reg ||
                        !(over_limit && (n_reg < drr_pkg::NRES_W'(drr_pkg::MAX_RESULTS - 1)));
    assign covers     = (def_reg >= DW'(size_q));

    always_comb begin
        flow_rec_t w;
        w          = rec_q;
        frd_en     = 1'b0;
        frd_addr   = '0;
        fwr_en     = 1'b0;
        fwr_addr   = '0;
        srd_en     = 1'b0;
        srd_addr   = '0;
        swr_en     = 1'b0;
        swr_addr   = '0;
        rrd_en     = 1'b0;
        ring_push  = 1'b0;
        ring_pop   = 1'b0;
        rwr_data   = ring_q;
        total_next = total_reg;
        case (cmd.op)
            drr_pkg::ST_INIT: begin
                fwr_en   = !init_done;
                fwr_addr = init_cnt_reg[FW-1:0];
                w        = '0;
            end
            drr_pkg::ST_ENQ_RD: begin
                frd_en   = 1'b1;
                frd_addr = enq_f;
            end
            drr_pkg::ST_ENQ_UPD: begin
                if (!full) begin
                    fwr_en     = 1'b1;
                    fwr_addr   = enq_f;
                    w.active   = 1'b1;
                    w.tail     = ptr_inc(rec_q.tail);
                    w.count    = rec_q.count + 1'b1;
                    w.backlog  = rec_q.backlog + BL_W'(isize_reg);
                    swr_en     = 1'b1;
                    swr_addr   = size_addr(enq_f, rec_q.tail);
                    total_next = total_reg + TW'(isize_reg);
                    ring_push  = !rec_q.active;
                    rwr_data   = enq_f;
                end
            end
            drr_pkg::ST_SCAN: begin
                frd_en   = (scan_cnt_reg < SCW'(FLOWS));
                frd_addr = scan_cnt_reg[FW-1:0];
            end
            drr_pkg::ST_DROP_RD: begin
                frd_en   = 1'b1;
                frd_addr = fat_reg;
            end
            drr_pkg::ST_DROP_SZ: begin
                srd_en   = 1'b1;
                srd_addr = size_addr(fat_reg, rec_q.head);
            end
            drr_pkg::ST_DROP_UPD: begin
                fwr_en     = 1'b1;
                fwr_addr   = fat_reg;
                w.head     = ptr_inc(rec_q.head);
                w.count    = rec_q.count - 1'b1;
                w.backlog  = rec_q.backlog - BL_W'(size_q);
                total_next = total_reg - TW'(size_q);
            end
            drr_pkg::ST_DQ_START: begin
                rrd_en = (ring_cnt_reg != '0);
            end
            drr_pkg::ST_DQ_RF: begin
                frd_en   = 1'b1;
                frd_addr = ring_q;
            end
            drr_pkg::ST_DQ_CHK: begin
                if (rec_q.count == '0) begin
                    // A flow emptied by drops is retired when it is visited.
                    fwr_en    = 1'b1;
                    fwr_addr  = ring_q;
                    w.deficit = '0;
                    w.active  = 1'b0;
                    ring_pop  = 1'b1;
                end else begin
                    srd_en   = 1'b1;
                    srd_addr = size_addr(ring_q, rec_q.head);
                end
            end
            drr_pkg::ST_DQ_SZ: begin
                fwr_en   = 1'b1;
                fwr_addr = ring_q;
                if (covers) begin
                    w.head     = ptr_inc(rec_q.head);
                    w.count    = rec_q.count - 1'b1;
                    w.backlog  = rec_q.backlog - BL_W'(size_q);
                    w.deficit  = def_reg - DW'(size_q);
                    total_next = total_reg - TW'(size_q);
                    if (rec_q.count == CW'(1)) begin
                        w.deficit = '0;
                        w.active  = 1'b0;
                        ring_pop  = 1'b1;
                    end
                end else begin
                    // Not enough credit: the flow moves to the ring tail.
                    w.deficit = def_reg;
                    ring_pop  = 1'b1;
                    ring_push = 1'b1;
                end
            end
            default: begin
            end
        endcase
        fwr_data = w;
    end

    always_ff @(posedge aclk) begin
        if (fwr_en) flow_mem[fwr_addr] <= fwr_data;
        if (frd_en) rec_q <= flow_mem[frd_addr];
    end

    always_ff @(posedge aclk) begin
        if (swr_en) size_mem[swr_addr] <= isize_reg;
        if (srd_en) size_q <= size_mem[srd_addr];
    end

    always_ff @(posedge aclk) begin
        if (ring_push) ring_mem[ring_tail_reg] <= rwr_data;
        if (rrd_en) ring_q <= ring_mem[ring_head_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg   <= drr_pkg::RESET_QUANTUM;
            limit_reg     <= drr_pkg::RESET_LIMIT;
            fiu_reg       <= drr_pkg::RESET_FIU;
            init_cnt_reg  <= '0;
            total_reg     <= '0;
            ring_head_reg <= '0;
            ring_tail_reg <= '0;
            ring_cnt_reg  <= '0;
            credited_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            scan_cnt_reg  <= '0;
            scan_pend_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    drr_pkg::CFG_QUANTUM:      quantum_reg <= cfg_data[drr_pkg::QUANTUM_W-1:0];
                    drr_pkg::CFG_BYTE_LIMIT:   limit_reg   <= cfg_data[drr_pkg::LIMIT_W-1:0];
                    drr_pkg::CFG_FLOWS_IN_USE: fiu_reg     <= cfg_data[drr_pkg::FIU_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.op == drr_pkg::ST_INIT && !init_done) begin
                init_cnt_reg <= init_cnt_reg + 1'b1;
            end
            total_reg <= total_next;
            if (ring_pop) ring_head_reg <= ring_inc(ring_head_reg);
            if (ring_push) ring_tail_reg <= ring_inc(ring_tail_reg);
            if (ring_push && !ring_pop) begin
                ring_cnt_reg <= ring_cnt_reg + 1'b1;
            end else if (ring_pop && !ring_push) begin
                ring_cnt_reg <= ring_cnt_reg - 1'b1;
            end
            if (cmd.op == drr_pkg::ST_DQ_CHK) begin
                credited_reg <= (rec_q.count != '0);
            end else if (cmd.op == drr_pkg::ST_DQ_SZ) begin
                credited_reg <= covers && (rec_q.count != CW'(1));
            end
            if (cmd.accept) begin
                n_reg <= '0;
            end else if (emit_load) begin
                n_reg <= n_reg + 1'b1;
            end
            if (emit_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (emit_load) begin
                scan_cnt_reg  <= '0;
                scan_pend_reg <= 1'b0;
            end else if (cmd.op == drr_pkg::ST_SCAN) begin
                if (scan_cnt_reg < SCW'(FLOWS)) begin
                    scan_cnt_reg  <= scan_cnt_reg + 1'b1;
                    scan_pend_reg <= 1'b1;
                end else begin
                    scan_pend_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            key_reg   <= s_tdata[drr_pkg::KEY_W-1:0];
            isize_reg <= s_tdata[drr_pkg::KEY_W +: SW];
            deq_reg   <= (s_tuser[0] == drr_pkg::OP_DEQUEUE);
            miss_reg  <= s_tuser[1] && (s_tuser[0] == drr_pkg::OP_ENQUEUE);
        end
        if (cmd.op == drr_pkg::ST_DECODE) begin
            rem_reg       <= '0;
            mod_cnt_reg   <= 5'(drr_pkg::KEY_W - 1);
            pend_kind_reg <= drr_pkg::KIND_UNCLASSIFIED;
            pend_flow_reg <= '0;
            pend_size_reg <= isize_reg;
        end
        if (cmd.op == drr_pkg::ST_MOD) begin
            rem_reg     <= rem_step;
            mod_cnt_reg <= mod_cnt_reg - 1'b1;
        end
        if (cmd.op == drr_pkg::ST_ENQ_UPD) begin
            pend_kind_reg <= full ? drr_pkg::KIND_FLOW_FULL : drr_pkg::KIND_ENQUEUED;
            pend_flow_reg <= enq_f;
            pend_size_reg <= isize_reg;
        end
        if (emit_load) begin
            best_reg <= '0;
            fat_reg  <= '0;
        end else if (cmd.op == drr_pkg::ST_SCAN) begin
            if (scan_pend_reg && (rec_q.backlog > best_reg)) begin
                best_reg <= rec_q.backlog;
                fat_reg  <= scan_idx_reg;
            end
            scan_idx_reg <= scan_cnt_reg[FW-1:0];
        end
        if (cmd.op == drr_pkg::ST_DROP_UPD) begin
            pend_kind_reg <= drr_pkg::KIND_OVERLIMIT;
            pend_flow_reg <= fat_reg;
            pend_size_reg <= size_q;
        end
        if (cmd.op == drr_pkg::ST_DQ_START) begin
            pend_kind_reg <= drr_pkg::KIND_EMPTY;
            pend_flow_reg <= '0;
            pend_size_reg <= '0;
        end
        if (cmd.op == drr_pkg::ST_DQ_CHK) begin
            def_reg <= credited_reg ? rec_q.deficit : rec_q.deficit + q_eff;
        end
        if (cmd.op == drr_pkg::ST_DQ_SZ) begin
            pend_kind_reg <= drr_pkg::KIND_DEQUEUED;
            pend_flow_reg <= ring_q;
            pend_size_reg <= size_q;
        end
        if (emit_load) begin
            out_kind_reg <= pend_kind_reg;
            out_flow_reg <= pend_flow_reg;
            out_size_reg <= pend_size_reg;
            out_last_reg <= last_emit;
        end
    end

    assign status.init_done  = init_done;
    assign status.is_deq     = deq_reg;
    assign status.is_miss    = miss_reg;
    assign status.mod_done   = (mod_cnt_reg == '0);
    assign status.out_free   = out_free;
    assign status.last_emit  = last_emit;
    assign status.scan_done  = (scan_cnt_reg == SCW'(FLOWS));
    assign status.ring_empty = (ring_cnt_reg == '0);
    assign status.flow_empty = (rec_q.count == '0);
    assign status.covers     = covers;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(drr_pkg::M_TDATA_W - drr_pkg::OFLOW_W - SW){1'b0}},
                       out_size_reg,
                       drr_pkg::OFLOW_W'(16'(out_flow_reg))};

    a_ring_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_cnt_reg <= SCW'(FLOWS))
        else $error("service ring count above flow count");

    a_result_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= drr_pkg::NRES_W'(drr_pkg::MAX_RESULTS))
        else $error("too many results for one transaction");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

### rtl/core/deficit_round_robin_scheduler_top.sv
// Every transaction is decoded and ends in a result load. Enqueue: the flow key is reduced
// one bit a cycle to a flow number, the flow record is read and updated, and each overlimit
// drop follows a backlog scan of the flow table. Dequeue: each ring entry visited takes a ring
// read, flow read, size read and update; an emptied flow is retired after its flow read.
// One transaction at a time. Reset (aresetn low, synchronous) clears control state, then a
// clearing pass zeroes the flow table; no input is taken until it ends.
module deficit_round_robin_scheduler_top #(
    parameter int FLOWS      = drr_pkg::DEF_FLOWS,
    parameter int FLOW_DEPTH = drr_pkg::DEF_FLOW_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [drr_pkg::S_TDATA_W-1:0]  s_tdata,  // flow_key, packet_size
    input  logic [drr_pkg::S_TUSER_W-1:0]  s_tuser,  // opcode, classify_miss
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [drr_pkg::M_TDATA_W-1:0]  m_tdata,  // flow, size
    output logic [drr_pkg::KIND_W-1:0]     m_tuser,  // kind
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [drr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [drr_pkg::CFG_DATA_W-1:0] cfg_data
);

    drr_pkg::drr_cmd_t    cmd;
    drr_pkg::drr_status_t status;

    assign cfg_ready = 1'b1;

    drr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    drr_dpath #(
        .FLOWS      (FLOWS),
        .FLOW_DEPTH (FLOW_DEPTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

### verif/testbench.sv
module testbench;
    import drr_pkg::*;

    localparam int NFLOWS    = DEF_FLOWS;
    localparam int NDEPTH    = DEF_FLOW_DEPTH;
    localparam int IDLE_STOP = 200000;

    typedef struct {
        drr_kind_t   kind;
        logic [5:0]  flow;
        logic [10:0] size;
        logic        last;
    } sched_event_t;

    typedef struct {
        logic        op;
        logic [30:0] key;
        logic        miss;
        logic [10:0] sz;
        bit          typed;
        drr_kind_t   kind;
        logic [5:0]  flow;
        logic [10:0] size;
    } stim_row_t;

    typedef struct {
        int unsigned quantum;
        int unsigned limit;
        int unsigned fiu;
        int          items;
        int          deq_pct;
        int          size_lo;
        int          size_hi;
        int          hot_pct;
        bit          drain_first;
    } phase_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    deficit_round_robin_scheduler_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Scheduler state as the predictor sees it.
    int unsigned deficit[NFLOWS];
    bit          active[NFLOWS];
    int unsigned backlog[NFLOWS];
    logic [10:0] pkt_sizes[NFLOWS][NDEPTH];
    int unsigned fhead[NFLOWS], ftail[NFLOWS], fcount[NFLOWS];
    int unsigned ring[NFLOWS];
    int unsigned rhead, rtail, rcount;
    int unsigned total_bytes;
    bit          front_credited;
    int unsigned quantum_reg, limit_reg, fiu_reg;

    sched_event_t pending_events[$];
    int errors;
    int idle_cycles;
    int burst_left;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    function automatic int unsigned pop_packet(input int unsigned f);
        int unsigned sz;
        sz = pkt_sizes[f][fhead[f]];
        fhead[f] = (fhead[f] + 1) % NDEPTH;
        fcount[f]--;
        backlog[f] -= sz;
        total_bytes -= sz;
        return sz;
    endfunction

    function automatic void ring_add(input int unsigned f);
        ring[rtail] = f;
        rtail = (rtail + 1) % NFLOWS;
        rcount++;
    endfunction

    function automatic int unsigned ring_take();
        int unsigned f;
        f = ring[rhead];
        rhead = (rhead + 1) % NFLOWS;
        rcount--;
        return f;
    endfunction

    function automatic void add_event(ref sched_event_t evs[$], input drr_kind_t k,
                                      input int unsigned f, input int unsigned sz);
        sched_event_t e;
        e.kind = k;
        e.flow = f[5:0];
        e.size = sz[10:0];
        e.last = 1'b0;
        evs = {evs, e};
    endfunction

    function automatic void predict_schedule(input logic op, input logic [30:0] key,
                                             input logic miss, input logic [10:0] sz,
                                             ref sched_event_t evs[$]);
        int unsigned modulus, f, best, fat, q, psz;
        evs.delete();
        if (op == OP_ENQUEUE) begin
            if (miss) begin
                add_event(evs, KIND_UNCLASSIFIED, 0, sz);
            end else begin
                modulus = fiu_reg;
                if (modulus == 0) modulus = 1;
                if (modulus > NFLOWS) modulus = NFLOWS;
                f = key % modulus;
                if (fcount[f] >= NDEPTH) begin
                    add_event(evs, KIND_FLOW_FULL, f, sz);
                end else begin
                    if (!active[f]) begin
                        active[f] = 1'b1;
                        ring_add(f);
                    end
                    pkt_sizes[f][ftail[f]] = sz;
                    ftail[f] = (ftail[f] + 1) % NDEPTH;
                    fcount[f]++;
                    backlog[f] += sz;
                    total_bytes += sz;
                    add_event(evs, KIND_ENQUEUED, f, sz);
                end
                // Trim the fattest flow; ties resolve to the lowest flow number.
                while (total_bytes > limit_reg && evs.size() < MAX_RESULTS) begin
                    best = 0;
                    fat = 0;
                    for (int i = 0; i < NFLOWS; i++) begin
                        if (backlog[i] > best) begin
                            best = backlog[i];
                            fat = i;
                        end
                    end
                    if (best == 0) break;
                    psz = pop_packet(fat);
                    add_event(evs, KIND_OVERLIMIT, fat, psz);
                end
            end
        end else begin
            q = (quantum_reg == 0) ? 1 : quantum_reg;
            forever begin
                if (rcount == 0) begin
                    add_event(evs, KIND_EMPTY, 0, 0);
                    break;
                end
                f = ring[rhead];
                if (fcount[f] == 0) begin
                    f = ring_take();
                    deficit[f] = 0;
                    active[f] = 1'b0;
                    front_credited = 1'b0;
                    continue;
                end
                if (!front_credited) begin
                    deficit[f] += q;
                    front_credited = 1'b1;
                end
                psz = pkt_sizes[f][fhead[f]];
                if (deficit[f] >= psz) begin
                    void'(pop_packet(f));
                    deficit[f] -= psz;
                    if (fcount[f] == 0) begin
                        f = ring_take();
                        deficit[f] = 0;
                        active[f] = 1'b0;
                        front_credited = 1'b0;
                    end
                    add_event(evs, KIND_DEQUEUED, f, psz);
                    break;
                end
                ring_add(ring_take());
                front_credited = 1'b0;
            end
        end
        evs[evs.size() - 1].last = 1'b1;
    endfunction

    task automatic send_packet(input logic op, input logic [30:0] key, input logic miss,
                               input logic [10:0] sz, output sched_event_t first);
        sched_event_t evs[$];
        s_tdata  <= {6'd0, sz, key};
        s_tuser  <= {miss, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_schedule(op, key, miss, sz, evs);
        first = evs[0];
        pending_events = {pending_events, evs};
        @(negedge aclk);
        // Bursts of back-to-back transactions separated by random gaps.
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 8);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_QUANTUM:      quantum_reg = value & 16'hFFFF;
            CFG_BYTE_LIMIT:   limit_reg   = value & 20'hFFFFF;
            CFG_FLOWS_IN_USE: fiu_reg     = value & 7'h7F;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Result checker.
    always @(posedge aclk) begin
        sched_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                report($sformatf("unexpected result kind %0d flow %0d size %0d",
                                 m_tuser, m_tdata[5:0], m_tdata[16:6]));
            end else begin
                want = pending_events[0];
                pending_events.delete(0);
                if (m_tuser !== want.kind)
                    report($sformatf("kind %0d, want %0d", m_tuser, want.kind));
                if (m_tdata[5:0] !== want.flow)
                    report($sformatf("flow %0d, want %0d", m_tdata[5:0], want.flow));
                if (m_tdata[16:6] !== want.size)
                    report($sformatf("size %0d, want %0d", m_tdata[16:6], want.size));
                if (m_tdata[23:17] !== 7'd0)
                    report("nonzero padding in m_tdata");
                if (m_tlast !== want.last)
                    report($sformatf("tlast %0b, want %0b", m_tlast, want.last));
            end
        end
    end

    // Receiver backpressure: a random stall pattern, sometimes fully open.
    logic [15:0] stall_mask;
    int          stall_pos;
    always @(negedge aclk) begin
        if (stall_pos == 0) begin
            stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end
        m_tready  <= (stall_pos == 0) ? 1'b1 : stall_mask[stall_pos[3:0]];
        stall_pos <= (stall_pos + 1) % 64;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_STOP) begin
            $display("** deficit_round_robin_scheduler_top: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    stim_row_t directed[] = '{
        '{OP_DEQUEUE, 31'd0,          1'b0, 11'd0,    1, KIND_EMPTY,        6'd0,  11'd0},
        '{OP_ENQUEUE, 31'd0,          1'b1, 11'd1518, 1, KIND_UNCLASSIFIED, 6'd0,  11'd1518},
        '{OP_ENQUEUE, 31'h7FFFFFFF,   1'b0, 11'd64,   1, KIND_ENQUEUED,     6'd63, 11'd64},
        '{OP_ENQUEUE, 31'd0,          1'b0, 11'd1518, 1, KIND_ENQUEUED,     6'd0,  11'd1518},
        '{OP_ENQUEUE, 31'd64,         1'b0, 11'd1518, 0, KIND_ENQUEUED,     6'd0,  11'd0},
        '{OP_ENQUEUE, 31'd1,          1'b0, 11'd700,  0, KIND_ENQUEUED,     6'd0,  11'd0},
        '{OP_DEQUEUE, 31'h7FFFFFFF,   1'b1, 11'd2047, 1, KIND_DEQUEUED,     6'd63, 11'd64},
        '{OP_DEQUEUE, 31'd0,          1'b0, 11'd0,    0, KIND_EMPTY,        6'd0,  11'd0},
        '{OP_ENQUEUE, 31'd5,          1'b1, 11'd64,   1, KIND_UNCLASSIFIED, 6'd0,  11'd64},
        '{OP_ENQUEUE, 31'd2,          1'b0, 11'd1518, 0, KIND_ENQUEUED,     6'd0,  11'd0},
        '{OP_ENQUEUE, 31'd3,          1'b0, 11'd1518, 0, KIND_ENQUEUED,     6'd0,  11'd0},
        '{OP_ENQUEUE, 31'd4,          1'b0, 11'd1518, 0, KIND_ENQUEUED,     6'd0,  11'd0},
        '{OP_ENQUEUE, 31'd128,        1'b0, 11'd1518, 0, KIND_ENQUEUED,     6'd0,  11'd0},
        '{OP_ENQUEUE, 31'd6,          1'b0, 11'd1518, 0, KIND_ENQUEUED,     6'd0,  11'd0},
        '{OP_ENQUEUE, 31'd7,          1'b0, 11'd1518, 0, KIND_ENQUEUED,     6'd0,  11'd0},
        '{OP_ENQUEUE, 31'h55555555,   1'b0, 11'd1000, 0, KIND_ENQUEUED,     6'd0,  11'd0},
        '{OP_ENQUEUE, 31'h2AAAAAAA,   1'b0, 11'd600,  0, KIND_ENQUEUED,     6'd0,  11'd0},
        '{OP_DEQUEUE, 31'd0,          1'b0, 11'd0,    0, KIND_EMPTY,        6'd0,  11'd0},
        '{OP_DEQUEUE, 31'd0,          1'b0, 11'd0,    0, KIND_EMPTY,        6'd0,  11'd0},
        '{OP_DEQUEUE, 31'd0,          1'b0, 11'd0,    0, KIND_EMPTY,        6'd0,  11'd0},
        '{OP_DEQUEUE, 31'd0,          1'b0, 11'd0,    0, KIND_EMPTY,        6'd0,  11'd0},
        '{OP_DEQUEUE, 31'd0,          1'b0, 11'd0,    0, KIND_EMPTY,        6'd0,  11'd0}
    };

    phase_t phases[] = '{
        '{65535, 1048575, 1,   45, 15, 64,   200,  0,  0},
        '{0,     1048575, 127, 40, 40, 64,   80,   0,  1},
        '{1500,  1048575, 64,  50, 0,  1200, 1518, 0,  0},
        '{1500,  1518,    64,  45, 30, 64,   1518, 50, 0},
        '{64,    5000,    5,   50, 45, 64,   1518, 30, 0},
        '{1500,  10240,   64,  40, 45, 64,   1518, 0,  0}
    };

    initial begin
        sched_event_t first;
        logic [30:0]  hot_key;
        logic [30:0]  key;
        logic         op;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_QUANTUM;
        cfg_data   = '0;
        stall_pos  = 0;
        stall_mask = 16'hFFFF;
        errors     = 0;
        idle_cycles = 0;
        burst_left = 0;
        quantum_reg = 1500;
        limit_reg   = 10 * 1024;
        fiu_reg     = 64;
        for (int i = 0; i < NFLOWS; i++) begin
            deficit[i] = 0; active[i] = 0; backlog[i] = 0;
            fhead[i] = 0; ftail[i] = 0; fcount[i] = 0;
        end
        rhead = 0; rtail = 0; rcount = 0;
        total_bytes = 0;
        front_credited = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            send_packet(directed[i].op, directed[i].key, directed[i].miss, directed[i].sz,
                        first);
            if (directed[i].typed && (first.kind !== directed[i].kind ||
                    first.flow !== directed[i].flow || first.size !== directed[i].size))
                report($sformatf("directed row %0d disagrees with the predictor", i));
        end

        foreach (phases[p]) begin
            wait_drained();
            // Emptying the ring keeps slow-credit phases from spinning for long.
            if (phases[p].drain_first) begin
                while (rcount != 0) send_packet(OP_DEQUEUE, 31'd0, 1'b0, 11'd0, first);
                wait_drained();
            end
            write_reg(CFG_QUANTUM, phases[p].quantum);
            write_reg(CFG_BYTE_LIMIT, phases[p].limit);
            write_reg(CFG_FLOWS_IN_USE, phases[p].fiu);
            hot_key = 31'($urandom);
            for (int n = 0; n < phases[p].items; n++) begin
                op  = ($urandom_range(0, 99) < phases[p].deq_pct) ? OP_DEQUEUE : OP_ENQUEUE;
                key = ($urandom_range(0, 99) < phases[p].hot_pct) ? hot_key : 31'($urandom);
                send_packet(op, key, $urandom_range(0, 99) < 8,
                            11'($urandom_range(phases[p].size_lo, phases[p].size_hi)),
                            first);
            end
        end

        wait_drained();
        repeat (40) @(negedge aclk);
        if (errors == 0) begin
            $display("** deficit_round_robin_scheduler_top: PASSED **");
        end else begin
            $display("** deficit_round_robin_scheduler_top: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/drr_pkg.sv
rtl/core/drr_ctrl.sv
rtl/core/drr_dpath.sv
rtl/core/deficit_round_robin_scheduler_top.sv
verif/testbench.sv
